// File: rtl/core/rc4_pkg.sv
// Shared constants, codes and types of the RC4 stream cipher block.
package rc4_pkg;

  // Table size must be a power of two up to 256 so that index sums wrap by truncation
  localparam int STATE_SIZE = 256;
  localparam int KEY_MAX    = 16;
  localparam int WORD_W     = 8;
  localparam int IDX_W      = $clog2(STATE_SIZE);
  localparam int KEY_AW     = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int KLEN_W     = 5;

  localparam logic [KLEN_W-1:0] KLEN_RESET = KLEN_W'(4);

  typedef enum logic [1:0] {
    CMD_KEY  = 2'd0,
    CMD_KSA  = 2'd1,
    CMD_ENC  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_E_RDJ,
    ST_E_WRI,
    ST_E_WRJ,
    ST_E_RDT,
    ST_E_OUT,
    ST_K_RDA,
    ST_K_ADD,
    ST_K_ADDK,
    ST_K_WRA,
    ST_K_WRB
  } state_t;

  typedef struct packed {
    logic              clr;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
  } perm_req_t;

  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] cipher;
    logic [WORD_W-1:0] ks;
  } result_t;

endpackage

// File: rtl/core/rc4_stream_cipher.sv
// Top level of the RC4 stream cipher: handshakes, key length register, result register.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_command[1:0], in_value[7:0]
//   out_     output     out_valid/out_stall out_cipher_word[7:0], out_keystream_word[7:0]
//   cfg_     input      cfg_wr_en          cfg_wr_data[4:0] (key_length)
//
// Load-key items leave the block idle; encrypt items are sequenced by three dependent reads,
// two writes and the result hand-off on the single permutation table port pair.
// Key schedule swaps per entry via RDA, ADD, ADDK, WRA, WRB: two table reads, two writes.
// Reset leaves the table as the identity through per-entry valid bits, no clearing pass.
// in_stall stays high while an item is in progress; a stalled result waits in the
// output register and the next item is still accepted behind it.
module rc4_stream_cipher (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_command,
  input  logic [rc4_pkg::WORD_W-1:0] in_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rc4_pkg::WORD_W-1:0] out_cipher_word,
  output logic [rc4_pkg::WORD_W-1:0] out_keystream_word,
  input  logic                       cfg_wr_en,
  input  logic [rc4_pkg::KLEN_W-1:0] cfg_wr_data
);
  import rc4_pkg::*;

  logic [KLEN_W-1:0] key_length_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_cipher_r;
  logic [WORD_W-1:0] out_ks_r;
  logic              out_free;
  logic              idle;
  perm_req_t         perm_req;
  logic [WORD_W-1:0] perm_rd_data;
  result_t           result;

  assign out_free = !out_valid_r || !out_stall;

  rc4_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_command   (in_command),
    .in_value     (in_value),
    .key_length   (key_length_r),
    .out_free     (out_free),
    .idle         (idle),
    .perm_req     (perm_req),
    .perm_rd_data (perm_rd_data),
    .result       (result)
  );

  rc4_perm u_perm (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (perm_req),
    .rd_data (perm_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= KLEN_RESET;
    end else if (cfg_wr_en) begin
      key_length_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (result.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      out_cipher_r <= result.cipher;
      out_ks_r     <= result.ks;
    end
  end

  assign in_stall           = !idle;
  assign out_valid          = out_valid_r;
  assign out_cipher_word    = out_cipher_r;
  assign out_keystream_word = out_ks_r;

  a_enc_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_command == CMD_ENC |=> in_stall)
    else $error("encrypt item did not make the block busy");

  a_key_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_command == CMD_KEY |=> !in_stall)
    else $error("key load item left the block busy");

  a_result_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    result.valid |-> (!out_valid_r || !out_stall))
    else $error("result issued over a pending output item");

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    result.valid |-> in_stall)
    else $error("result issued while the block was idle");

endmodule

// File: rtl/core/rc4_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/rc4_perm.sv
// Permutation table: RAM plus per-entry valid bits; an unwritten entry reads as its index.
module rc4_perm (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rc4_pkg::perm_req_t         req,
  output logic [rc4_pkg::WORD_W-1:0] rd_data
);
  import rc4_pkg::*;

  logic [STATE_SIZE-1:0] vld_r;
  logic                  vld_q_r;
  logic [IDX_W-1:0]      addr_q_r;
  logic [WORD_W-1:0]     ram_q;

  rc4_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STATE_SIZE)
  ) u_ram (
    .clk     (clk),
    .wr_en   (req.wr_en),
    .wr_addr (req.wr_addr),
    .wr_data (req.wr_data),
    .rd_en   (req.rd_en),
    .rd_addr (req.rd_addr),
    .rd_data (ram_q)
  );

  // clearing all valid bits restores the identity permutation at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.clr) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      vld_q_r  <= vld_r[req.rd_addr];
      addr_q_r <= req.rd_addr;
    end
  end

  assign rd_data = vld_q_r ? ram_q : WORD_W'(addr_q_r);

endmodule

// File: rtl/core/rc4_ctrl.sv
// Sequencer with one shared index adder: key store, key schedule and keystream steps.
module rc4_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [1:0]                 in_command,
  input  logic [rc4_pkg::WORD_W-1:0] in_value,
  input  logic [rc4_pkg::KLEN_W-1:0] key_length,
  input  logic                       out_free,
  output logic                       idle,
  output rc4_pkg::perm_req_t         perm_req,
  input  logic [rc4_pkg::WORD_W-1:0] perm_rd_data,
  output rc4_pkg::result_t           result
);
  import rc4_pkg::*;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt;
  logic [IDX_W-1:0]  j_r, j_nxt;
  logic [IDX_W-1:0]  t_r, t_nxt;
  logic [WORD_W-1:0] si_r, si_nxt;
  logic [WORD_W-1:0] sj_r, sj_nxt;
  logic [WORD_W-1:0] val_r, val_nxt;
  logic [KEY_AW-1:0] kidx_r, kidx_nxt;
  logic [KEY_AW-1:0] key_wpos_r, key_wpos_nxt;
  logic [WORD_W-1:0] key_mem_r [KEY_MAX];
  logic              key_we;

  logic [IDX_W-1:0]  add_a, add_b, add_sum;
  logic [KLEN_W-1:0] eff_len;
  logic [KEY_AW-1:0] kidx_inc;
  logic              accept;
  cmd_t              cmd;

  assign add_sum = add_a + add_b;
  assign cmd     = cmd_t'(in_command);
  assign accept  = in_valid && (state_r == ST_IDLE);
  assign idle    = (state_r == ST_IDLE);

  // zero length acts as one, lengths past the store saturate
  always_comb begin
    eff_len = key_length;
    if (key_length == '0) begin
      eff_len = KLEN_W'(1);
    end else if (key_length > KLEN_W'(KEY_MAX)) begin
      eff_len = KLEN_W'(KEY_MAX);
    end
  end

  assign kidx_inc = (KLEN_W'(kidx_r) == eff_len - KLEN_W'(1)) ? '0 : kidx_r + KEY_AW'(1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_KSA: state_nxt = ST_K_RDA;
            CMD_ENC: state_nxt = ST_E_RDJ;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_E_RDJ:  state_nxt = ST_E_WRI;
      ST_E_WRI:  state_nxt = ST_E_WRJ;
      ST_E_WRJ:  state_nxt = ST_E_RDT;
      ST_E_RDT:  state_nxt = ST_E_OUT;
      ST_E_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_K_RDA:  state_nxt = ST_K_ADD;
      ST_K_ADD:  state_nxt = ST_K_ADDK;
      ST_K_ADDK: state_nxt = ST_K_WRA;
      ST_K_WRA:  state_nxt = ST_K_WRB;
      ST_K_WRB: begin
        state_nxt = (i_r == IDX_W'(STATE_SIZE - 1)) ? ST_IDLE : ST_K_RDA;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    perm_req     = '0;
    result       = '0;
    add_a        = i_r;
    add_b        = IDX_W'(1);
    i_nxt        = i_r;
    j_nxt        = j_r;
    t_nxt        = t_r;
    si_nxt       = si_r;
    sj_nxt       = sj_r;
    val_nxt      = val_r;
    kidx_nxt     = kidx_r;
    key_wpos_nxt = key_wpos_r;
    key_we       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_KEY: begin
              key_we       = 1'b1;
              key_wpos_nxt = (key_wpos_r == KEY_AW'(KEY_MAX - 1)) ? '0
                                                                   : key_wpos_r + KEY_AW'(1);
            end
            CMD_KSA: begin
              perm_req.clr = 1'b1;
              i_nxt        = '0;
              j_nxt        = '0;
              kidx_nxt     = '0;
            end
            CMD_ENC: begin
              i_nxt            = add_sum;
              perm_req.rd_en   = 1'b1;
              perm_req.rd_addr = add_sum;
              val_nxt          = in_value;
            end
            default: begin
            end
          endcase
        end
      end
      ST_E_RDJ: begin
        si_nxt           = perm_rd_data;
        add_a            = j_r;
        add_b            = IDX_W'(perm_rd_data);
        j_nxt            = add_sum;
        perm_req.rd_en   = 1'b1;
        perm_req.rd_addr = add_sum;
      end
      ST_E_WRI: begin
        sj_nxt           = perm_rd_data;
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = i_r;
        perm_req.wr_data = perm_rd_data;
      end
      ST_E_WRJ: begin
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = j_r;
        perm_req.wr_data = si_r;
        add_a            = IDX_W'(si_r);
        add_b            = IDX_W'(sj_r);
        t_nxt            = add_sum;
      end
      ST_E_RDT: begin
        perm_req.rd_en   = 1'b1;
        perm_req.rd_addr = t_r;
      end
      ST_E_OUT: begin
        // hold the keystream word until the output slot frees up
        if (out_free) begin
          result.valid  = 1'b1;
          result.cipher = val_r ^ perm_rd_data;
          result.ks     = perm_rd_data;
        end
      end
      ST_K_RDA: begin
        perm_req.rd_en   = 1'b1;
        perm_req.rd_addr = i_r;
      end
      ST_K_ADD: begin
        si_nxt = perm_rd_data;
        add_a  = j_r;
        add_b  = IDX_W'(perm_rd_data);
        t_nxt  = add_sum;
      end
      ST_K_ADDK: begin
        add_a            = t_r;
        add_b            = IDX_W'(key_mem_r[kidx_r]);
        j_nxt            = add_sum;
        perm_req.rd_en   = 1'b1;
        perm_req.rd_addr = add_sum;
      end
      ST_K_WRA: begin
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = i_r;
        perm_req.wr_data = perm_rd_data;
      end
      ST_K_WRB: begin
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = j_r;
        perm_req.wr_data = si_r;
        kidx_nxt         = kidx_inc;
        // last step: leave both generator indices at zero
        if (i_r == IDX_W'(STATE_SIZE - 1)) begin
          i_nxt = '0;
          j_nxt = '0;
        end else begin
          i_nxt = add_sum;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      i_r        <= '0;
      j_r        <= '0;
      kidx_r     <= '0;
      key_wpos_r <= '0;
    end else begin
      state_r    <= state_nxt;
      i_r        <= i_nxt;
      j_r        <= j_nxt;
      kidx_r     <= kidx_nxt;
      key_wpos_r <= key_wpos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r   <= t_nxt;
    si_r  <= si_nxt;
    sj_r  <= sj_nxt;
    val_r <= val_nxt;
    if (key_we) begin
      key_mem_r[key_wpos_r] <= in_value;
    end
  end

endmodule
